/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared assertion forms for the projection term checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define PPT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ppt assertion failed");

// checked on every edge, reset included
`define PPT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ppt assertion failed");

`endif

/* hdl/ppt_pkg.sv */
// ----------------------------------------------------------------------------
// ppt_pkg
// widths, constants, arctangent table and sideband types of the projection
// term pipeline
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int FOV_W        = 24;
  localparam int ASP_W        = 31;
  localparam int DAT_W        = 32;
  localparam int ANG_W        = 33;
  localparam int ROT_W        = 33;
  localparam int VEC_W        = 44;
  localparam int MAG_W        = 64;
  localparam int DEN_W        = 34;
  localparam int UD_W         = 33;
  localparam int QUO_W        = 32;
  localparam int PROD_W       = 62;
  localparam int NORM_BIT     = 40;
  localparam int SH_W         = 5;

  localparam logic [FOV_W-1:0] FOV_MAX    = 24'd11730944;
  localparam logic [34:0]      DEG_FACTOR = 35'd19190098069;
  localparam logic [63:0]      HALF_LIMIT_W =
    (64'(FOV_MAX) * 64'(DEG_FACTOR) + 64'd67108864) >> 27;
  localparam logic signed [ANG_W-1:0] HALF_LIMIT = HALF_LIMIT_W[ANG_W-1:0];
  localparam logic signed [ROT_W-1:0] ROT_ONE = ROT_W'(64'd1073741824);

  localparam logic signed [QUO_W-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [QUO_W-1:0] Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic [ASP_W-1:0]        aspect;
    logic signed [DAT_W-1:0] near_plane;
    logic signed [DAT_W-1:0] far_plane;
  } geo_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] ang;
    geo_t                    geo;
  } ang_side_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] cos_v;
    logic signed [ROT_W-1:0] sin_v;
    logic signed [DAT_W-1:0] near_plane;
    logic signed [DAT_W-1:0] far_plane;
  } cot_side_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] ang;
    cot_side_t               cs;
  } hw_side_t;

  typedef struct packed {
    logic ovf;
    logic neg;
    logic nzn;
    logic zero;
  } div_flags_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 33'sd843314857;
      5'd1:  v = 33'sd497837829;
      5'd2:  v = 33'sd263043837;
      5'd3:  v = 33'sd133525159;
      5'd4:  v = 33'sd67021687;
      5'd5:  v = 33'sd33543516;
      5'd6:  v = 33'sd16775851;
      5'd7:  v = 33'sd8388437;
      5'd8:  v = 33'sd4194283;
      5'd9:  v = 33'sd2097149;
      5'd10: v = 33'sd1048576;
      5'd11: v = 33'sd524288;
      5'd12: v = 33'sd262144;
      5'd13: v = 33'sd131072;
      5'd14: v = 33'sd65536;
      5'd15: v = 33'sd32768;
      5'd16: v = 33'sd16384;
      5'd17: v = 33'sd8192;
      5'd18: v = 33'sd4096;
      5'd19: v = 33'sd2048;
      5'd20: v = 33'sd1024;
      5'd21: v = 33'sd512;
      5'd22: v = 33'sd256;
      5'd23: v = 33'sd128;
      5'd24: v = 33'sd64;
      5'd25: v = 33'sd32;
      5'd26: v = 33'sd16;
      5'd27: v = 33'sd8;
      5'd28: v = 33'sd4;
      5'd29: v = 33'sd2;
      5'd30: v = 33'sd1;
      5'd31: v = 33'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/ppt_if.sv */
// ----------------------------------------------------------------------------
// ppt_in_if / ppt_out_if
// valid/ready channels carrying projection parameters and matrix terms
// ----------------------------------------------------------------------------
interface ppt_in_if;
  logic               valid;
  logic               ready;
  logic [23:0]        fov_x_deg;
  logic [30:0]        aspect;
  logic signed [31:0] near_plane;
  logic signed [31:0] far_plane;

  modport source (output valid, fov_x_deg, aspect, near_plane, far_plane, input ready);
  modport sink   (input valid, fov_x_deg, aspect, near_plane, far_plane, output ready);
endinterface

interface ppt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_scale;
  logic signed [31:0] y_scale;
  logic signed [31:0] depth_scale;
  logic signed [31:0] depth_offset;
  logic               depth_invalid;
  logic               saturated;

  modport source (output valid, x_scale, y_scale, depth_scale, depth_offset,
                  depth_invalid, saturated, input ready);
  modport sink   (input valid, x_scale, y_scale, depth_scale, depth_offset,
                  depth_invalid, saturated, output ready);
endinterface

/* hdl/ppt_rot.sv */
// ----------------------------------------------------------------------------
// ppt_rot
// pipelined cordic rotation, one step per stage, from (2^30, 0) by an angle
// ----------------------------------------------------------------------------
module ppt_rot #(
  parameter int STEPS  = ppt_pkg::CORDIC_STEPS,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [ppt_pkg::ANG_W-1:0]  ang,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              out_valid,
  output logic signed [ppt_pkg::ROT_W-1:0]  cos_out,
  output logic signed [ppt_pkg::ROT_W-1:0]  sin_out,
  output logic [SIDE_W-1:0]                 side_out
);
  import ppt_pkg::*;

  logic signed [ROT_W-1:0] x [0:STEPS];
  logic signed [ROT_W-1:0] y [0:STEPS];
  logic signed [ANG_W-1:0] z [0:STEPS];
  logic [SIDE_W-1:0]       sd [0:STEPS];
  logic                    vld [0:STEPS];

  assign x[0]   = ROT_ONE;
  assign y[0]   = '0;
  assign z[0]   = ang;
  assign sd[0]  = side_in;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        sd[k+1] <= sd[k];
        if (z[k] >= 0) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - atan_q30(5'(k));
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + atan_q30(5'(k));
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign cos_out   = x[STEPS];
  assign sin_out   = y[STEPS];
  assign side_out  = sd[STEPS];

endmodule

/* hdl/ppt_vec.sv */
// ----------------------------------------------------------------------------
// ppt_vec
// vertical half angle: scale cos by aspect, normalize below 2^40, then a
// pipelined cordic vectoring run, one step per stage
// ----------------------------------------------------------------------------
module ppt_vec #(
  parameter int STEPS  = ppt_pkg::CORDIC_STEPS,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [ppt_pkg::ROT_W-1:0]  cos_in,
  input  logic signed [ppt_pkg::ROT_W-1:0]  sin_in,
  input  logic [ppt_pkg::ASP_W-1:0]         aspect,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              out_valid,
  output logic signed [ppt_pkg::ANG_W-1:0]  angle,
  output logic [SIDE_W-1:0]                 side_out
);
  import ppt_pkg::*;

  logic [30:0]        cc;
  logic [30:0]        sc;
  logic               p_vld;
  logic [PROD_W-1:0]  p_bx;
  logic [PROD_W-1:0]  p_by;
  logic [SIDE_W-1:0]  p_sd;
  logic               n_vld;
  logic [PROD_W-1:0]  n_bx;
  logic [PROD_W-1:0]  n_by;
  logic [SIDE_W-1:0]  n_sd;
  logic [SH_W-1:0]    n_sh;
  logic [SH_W-1:0]    sh_next;
  logic [PROD_W-1:0]  orv;
  logic [PROD_W-1:0]  bx_sh;
  logic [PROD_W-1:0]  by_sh;

  logic signed [VEC_W-1:0] x [0:STEPS];
  logic signed [VEC_W-1:0] y [0:STEPS];
  logic signed [ANG_W-1:0] z [0:STEPS];
  logic [SIDE_W-1:0]       sd [0:STEPS];
  logic                    vld [0:STEPS];

  assign cc = (cos_in < 0) ? '0 : cos_in[30:0];
  assign sc = (sin_in < 0) ? '0 : sin_in[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= in_valid;
    end
    if (en) begin
      p_bx <= PROD_W'(cc) * PROD_W'(aspect);
      p_by <= PROD_W'({sc, 16'd0});
      p_sd <= side_in;
    end
  end

  assign orv = p_bx | p_by;

  always_comb begin
    sh_next = '0;
    for (int b = 0; b < PROD_W - NORM_BIT; b++) begin
      if (orv[NORM_BIT + b]) sh_next = SH_W'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else if (en) begin
      n_vld <= p_vld;
    end
    if (en) begin
      n_bx <= p_bx;
      n_by <= p_by;
      n_sh <= sh_next;
      n_sd <= p_sd;
    end
  end

  assign bx_sh = n_bx >> n_sh;
  assign by_sh = n_by >> n_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= n_vld;
    end
    if (en) begin
      x[0]  <= signed'(bx_sh[VEC_W-1:0]);
      y[0]  <= signed'(by_sh[VEC_W-1:0]);
      z[0]  <= '0;
      sd[0] <= n_sd;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        sd[k+1] <= sd[k];
        if (y[k] > 0) begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + atan_q30(5'(k));
        end else begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - atan_q30(5'(k));
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign angle     = (z[STEPS] < 0) ? '0 : z[STEPS];
  assign side_out  = sd[STEPS];

endmodule

/* hdl/ppt_div.sv */
// ----------------------------------------------------------------------------
// ppt_div
// pipelined restoring divider, one quotient bit per stage, with signed
// result saturated to 32 bits
// ----------------------------------------------------------------------------
module ppt_div #(
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [ppt_pkg::MAG_W-1:0]         mag,
  input  logic                              numneg,
  input  logic signed [ppt_pkg::DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0]                 side_in,
  output logic                              out_valid,
  output logic signed [ppt_pkg::QUO_W-1:0]  quot,
  output logic                              clip,
  output logic [SIDE_W-1:0]                 side_out
);
  import ppt_pkg::*;

  logic               a_vld;
  logic [MAG_W-1:0]   a_mag;
  logic [UD_W-1:0]    a_ud;
  div_flags_t         a_fl;
  logic [SIDE_W-1:0]  a_sd;
  div_flags_t         fl_next;

  logic [UD_W-1:0]    ud [0:QUO_W];
  logic [UD_W-1:0]    r  [0:QUO_W];
  logic [QUO_W-1:0]   q  [0:QUO_W];
  logic [QUO_W-1:0]   lo [0:QUO_W];
  div_flags_t         fl [0:QUO_W];
  logic [SIDE_W-1:0]  sd [0:QUO_W];
  logic               vld [0:QUO_W];

  logic               o_vld;
  logic signed [QUO_W-1:0] o_q;
  logic               o_clip;
  logic [SIDE_W-1:0]  o_sd;

  always_comb begin
    fl_next.ovf  = 1'b0;
    fl_next.neg  = numneg != (den < 0);
    fl_next.nzn  = numneg && (mag != '0);
    fl_next.zero = (den == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
    if (en) begin
      a_mag <= mag;
      a_ud  <= (den < 0) ? UD_W'(-den) : UD_W'(den);
      a_fl  <= fl_next;
      a_sd  <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= a_vld;
    end
    if (en) begin
      ud[0]     <= a_ud;
      r[0]      <= UD_W'(a_mag[MAG_W-1:QUO_W]);
      lo[0]     <= a_mag[QUO_W-1:0];
      q[0]      <= '0;
      fl[0]     <= '{ovf: (UD_W'(a_mag[MAG_W-1:QUO_W]) >= a_ud), neg: a_fl.neg,
                     nzn: a_fl.nzn, zero: a_fl.zero};
      sd[0]     <= a_sd;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_bit
    logic [UD_W:0] t;
    assign t = {r[j], lo[j][QUO_W-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
      if (en) begin
        ud[j+1] <= ud[j];
        lo[j+1] <= lo[j] << 1;
        fl[j+1] <= fl[j];
        sd[j+1] <= sd[j];
        if (t >= {1'b0, ud[j]}) begin
          r[j+1] <= UD_W'(t - {1'b0, ud[j]});
          q[j+1] <= {q[j][QUO_W-2:0], 1'b1};
        end else begin
          r[j+1] <= t[UD_W-1:0];
          q[j+1] <= {q[j][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= vld[QUO_W];
    end
    if (en) begin
      o_sd <= sd[QUO_W];
      if (fl[QUO_W].zero) begin
        o_clip <= 1'b1;
        o_q    <= fl[QUO_W].nzn ? Q_MIN : Q_MAX;
      end else if (fl[QUO_W].ovf) begin
        o_clip <= 1'b1;
        o_q    <= fl[QUO_W].neg ? Q_MIN : Q_MAX;
      end else if (fl[QUO_W].neg) begin
        o_clip <= q[QUO_W][QUO_W-1] && (q[QUO_W][QUO_W-2:0] != '0);
        o_q    <= (q[QUO_W][QUO_W-1] && (q[QUO_W][QUO_W-2:0] != '0)) ? Q_MIN
                  : signed'(QUO_W'(-q[QUO_W]));
      end else begin
        o_clip <= q[QUO_W][QUO_W-1];
        o_q    <= q[QUO_W][QUO_W-1] ? Q_MAX : signed'(q[QUO_W]);
      end
    end
  end

  assign out_valid = o_vld;
  assign quot      = o_q;
  assign clip      = o_clip;
  assign side_out  = o_sd;

endmodule

/* hdl/perspective_projection_terms.sv */
// ----------------------------------------------------------------------------
// perspective_projection_terms
// four varying perspective matrix terms from field of view, aspect and planes
// ----------------------------------------------------------------------------
// params (sink): fov_x_deg, aspect, near_plane, far_plane, one transaction per
//   view set-up. terms (source): x_scale, y_scale, depth_scale, depth_offset,
//   depth_invalid and saturated, one transaction per params transaction,
//   in order.
// Throughput: one transaction per cycle while terms is not stalled. The
//   pipeline is made of three cordic rotations, two cordic vectoring runs
//   and the 32-stage quotient pipeline, each one stage per step.
// Reset clears every valid bit in the pipeline and the output register; no
//   clearing time is needed after reset.
// When terms is stalled with a result waiting, the whole pipeline holds and
//   params.ready is low; nothing is dropped or repeated. Bubbles advance
//   freely while the output register is empty or being taken.
// ----------------------------------------------------------------------------
module perspective_projection_terms #(
  parameter int CORDIC_STEPS = ppt_pkg::CORDIC_STEPS
) (
  input  logic      clk,
  input  logic      rst,
  ppt_in_if.sink    params,
  ppt_out_if.source terms
);
  import ppt_pkg::*;

  logic en;

  logic [FOV_W-1:0] fov_c;
  logic             a_vld;
  logic [41:0]      a_plo;
  logic [40:0]      a_phi;
  geo_t             a_geo;
  logic [63:0]      hx_sum;
  logic             b_vld;
  logic signed [ANG_W-1:0] b_hx;
  geo_t             b_geo;

  logic             r1_vld;
  logic signed [ROT_W-1:0] r1_c;
  logic signed [ROT_W-1:0] r1_s;
  ang_side_t        r1_sd;
  logic             v1_vld;
  logic signed [ANG_W-1:0] v1_ang;
  ang_side_t        v1_sd;

  logic signed [ANG_W:0]   diff;
  logic signed [ANG_W:0]   half;
  logic signed [ANG_W+1:0] hw_raw;
  logic             w_vld;
  logic signed [ANG_W-1:0] w_hw;
  geo_t             w_geo;

  logic             r2_vld;
  logic signed [ROT_W-1:0] r2_c;
  logic signed [ROT_W-1:0] r2_s;
  ang_side_t        r2_sd;
  hw_side_t         v2_in;
  logic             v2_vld;
  logic signed [ANG_W-1:0] v2_ang;
  hw_side_t         v2_sd;

  logic             y_vld;
  logic signed [ANG_W-1:0] y_hy2;
  cot_side_t        y_cs;

  logic             r3_vld;
  logic signed [ROT_W-1:0] r3_c;
  logic signed [ROT_W-1:0] r3_s;
  cot_side_t        r3_sd;

  logic             e1_vld;
  logic signed [DEN_W-1:0] e1_d;
  logic signed [DAT_W:0]   e1_sum;
  logic signed [63:0]      e1_prod;
  logic signed [ROT_W-1:0] e1_c2, e1_s2, e1_c3, e1_s3;

  logic [ROT_W-1:0] ac2, ac3;
  logic [DAT_W:0]   asum;
  logic [63:0]      aprod;

  logic             e2_vld;
  logic [MAG_W-1:0] e2_mx, e2_my, e2_ms, e2_mo;
  logic             e2_nx, e2_ny, e2_ns, e2_no;
  logic signed [DEN_W-1:0] e2_dx, e2_dy, e2_d;
  logic             e2_dinv;

  logic             d_vld;
  logic signed [QUO_W-1:0] qx, qy, qs, qo;
  logic             cx, cy, cs, co;
  logic             d_dinv;

  logic             o_vld;
  logic signed [QUO_W-1:0] o_x, o_y, o_s, o_o;
  logic             o_dinv, o_sat;

  assign en = !o_vld || terms.ready;
  assign params.ready = en;

  // stage a: clamp fov, split product by the degree to radian factor
  always_comb begin
    if (params.fov_x_deg == '0) begin
      fov_c = FOV_W'(1);
    end else if (params.fov_x_deg > FOV_MAX) begin
      fov_c = FOV_MAX;
    end else begin
      fov_c = params.fov_x_deg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= params.valid;
    end
    if (en) begin
      a_plo <= 42'(fov_c) * 42'(DEG_FACTOR[17:0]);
      a_phi <= 41'(fov_c) * 41'(DEG_FACTOR[34:18]);
      a_geo.aspect     <= params.aspect;
      a_geo.near_plane <= params.near_plane;
      a_geo.far_plane  <= params.far_plane;
    end
  end

  // stage b: half horizontal angle, Q30 radians rounded to nearest
  assign hx_sum = 64'(a_plo) + (64'(a_phi) << 18) + 64'd67108864;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
    if (en) begin
      b_hx  <= signed'(hx_sum[27 +: ANG_W]);
      b_geo <= a_geo;
    end
  end

  ppt_rot #(.STEPS(CORDIC_STEPS), .SIDE_W($bits(ang_side_t))) u_rot_hx (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(b_vld), .ang(b_hx), .side_in({b_hx, b_geo}),
    .out_valid(r1_vld), .cos_out(r1_c), .sin_out(r1_s), .side_out(r1_sd)
  );

  ppt_vec #(.STEPS(CORDIC_STEPS), .SIDE_W($bits(ang_side_t))) u_vec_hy (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(r1_vld), .cos_in(r1_c), .sin_in(r1_s), .aspect(r1_sd.geo.aspect),
    .side_in(r1_sd), .out_valid(v1_vld), .angle(v1_ang), .side_out(v1_sd)
  );

  // widened half horizontal angle
  assign diff   = (ANG_W+1)'(v1_sd.ang) - (ANG_W+1)'(v1_ang);
  assign half   = (diff + signed'((ANG_W+1)'(diff < 0))) >>> 1;
  assign hw_raw = (ANG_W+2)'(v1_sd.ang) + (ANG_W+2)'(half);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_vld <= 1'b0;
    end else if (en) begin
      w_vld <= v1_vld;
    end
    if (en) begin
      w_hw  <= (hw_raw > (ANG_W+2)'(HALF_LIMIT)) ? HALF_LIMIT : hw_raw[ANG_W-1:0];
      w_geo <= v1_sd.geo;
    end
  end

  ppt_rot #(.STEPS(CORDIC_STEPS), .SIDE_W($bits(ang_side_t))) u_rot_hw (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(w_vld), .ang(w_hw), .side_in({w_hw, w_geo}),
    .out_valid(r2_vld), .cos_out(r2_c), .sin_out(r2_s), .side_out(r2_sd)
  );

  always_comb begin
    v2_in.ang           = r2_sd.ang;
    v2_in.cs.cos_v      = r2_c;
    v2_in.cs.sin_v      = r2_s;
    v2_in.cs.near_plane = r2_sd.geo.near_plane;
    v2_in.cs.far_plane  = r2_sd.geo.far_plane;
  end

  ppt_vec #(.STEPS(CORDIC_STEPS), .SIDE_W($bits(hw_side_t))) u_vec_hy2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(r2_vld), .cos_in(r2_c), .sin_in(r2_s), .aspect(r2_sd.geo.aspect),
    .side_in(v2_in), .out_valid(v2_vld), .angle(v2_ang), .side_out(v2_sd)
  );

  // vertical half angle, limit when the widened angle went negative or the angle exceeds the limit
  always_ff @(posedge clk) begin
    if (rst) begin
      y_vld <= 1'b0;
    end else if (en) begin
      y_vld <= v2_vld;
    end
    if (en) begin
      y_hy2 <= (v2_sd.ang < 0 || v2_ang > HALF_LIMIT) ? HALF_LIMIT : v2_ang;
      y_cs  <= v2_sd.cs;
    end
  end

  ppt_rot #(.STEPS(CORDIC_STEPS), .SIDE_W($bits(cot_side_t))) u_rot_hy (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(y_vld), .ang(y_hy2), .side_in(y_cs),
    .out_valid(r3_vld), .cos_out(r3_c), .sin_out(r3_s), .side_out(r3_sd)
  );

  // depth terms: difference, sum, product
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_vld <= 1'b0;
    end else if (en) begin
      e1_vld <= r3_vld;
    end
    if (en) begin
      e1_d    <= DEN_W'(r3_sd.far_plane) - DEN_W'(r3_sd.near_plane);
      e1_sum  <= (DAT_W+1)'(r3_sd.far_plane) + (DAT_W+1)'(r3_sd.near_plane);
      e1_prod <= 64'(r3_sd.far_plane) * 64'(r3_sd.near_plane);
      e1_c2   <= r3_sd.cos_v;
      e1_s2   <= r3_sd.sin_v;
      e1_c3   <= r3_c;
      e1_s3   <= r3_s;
    end
  end

  assign ac2   = (e1_c2 < 0) ? ROT_W'(-e1_c2) : ROT_W'(e1_c2);
  assign ac3   = (e1_c3 < 0) ? ROT_W'(-e1_c3) : ROT_W'(e1_c3);
  assign asum  = (e1_sum < 0) ? (DAT_W+1)'(-e1_sum) : (DAT_W+1)'(e1_sum);
  assign aprod = (e1_prod < 0) ? 64'(-e1_prod) : 64'(e1_prod);

  // numerator magnitudes and signs for the four quotients
  always_ff @(posedge clk) begin
    if (rst) begin
      e2_vld <= 1'b0;
    end else if (en) begin
      e2_vld <= e1_vld;
    end
    if (en) begin
      e2_mx   <= MAG_W'(ac2) << 16;
      e2_nx   <= e1_c2 < 0;
      e2_dx   <= DEN_W'(e1_s2);
      e2_my   <= MAG_W'(ac3) << 16;
      e2_ny   <= e1_c3 < 0;
      e2_dy   <= DEN_W'(e1_s3);
      e2_ms   <= MAG_W'(asum) << 16;
      e2_ns   <= e1_sum > 0;
      e2_mo   <= aprod << 1;
      e2_no   <= e1_prod > 0;
      e2_d    <= e1_d;
      e2_dinv <= e1_d == '0;
    end
  end

  ppt_div #(.SIDE_W(1)) u_div_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(e2_vld),
    .mag(e2_mx), .numneg(e2_nx), .den(e2_dx), .side_in(1'b0),
    .out_valid(), .quot(qx), .clip(cx), .side_out()
  );

  ppt_div #(.SIDE_W(1)) u_div_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(e2_vld),
    .mag(e2_my), .numneg(e2_ny), .den(e2_dy), .side_in(1'b0),
    .out_valid(), .quot(qy), .clip(cy), .side_out()
  );

  ppt_div #(.SIDE_W(1)) u_div_ds (
    .clk(clk), .rst(rst), .en(en), .in_valid(e2_vld),
    .mag(e2_ms), .numneg(e2_ns), .den(e2_d), .side_in(1'b0),
    .out_valid(), .quot(qs), .clip(cs), .side_out()
  );

  ppt_div #(.SIDE_W(1)) u_div_do (
    .clk(clk), .rst(rst), .en(en), .in_valid(e2_vld),
    .mag(e2_mo), .numneg(e2_no), .den(e2_d), .side_in(e2_dinv),
    .out_valid(d_vld), .quot(qo), .clip(co), .side_out(d_dinv)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= d_vld;
    end
    if (en) begin
      o_x    <= qx;
      o_y    <= qy;
      o_s    <= qs;
      o_o    <= qo;
      o_dinv <= d_dinv;
      o_sat  <= cx | cy | cs | co;
    end
  end

  assign terms.valid         = o_vld;
  assign terms.x_scale       = o_x;
  assign terms.y_scale       = o_y;
  assign terms.depth_scale   = o_s;
  assign terms.depth_offset  = o_o;
  assign terms.depth_invalid = o_dinv;
  assign terms.saturated     = o_sat;

endmodule

/* hdl/ppt_chk.sv */
// ----------------------------------------------------------------------------
// ppt_chk
// port-level checks of the projection term block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppt_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] x_scale,
  input logic        depth_invalid,
  input logic        saturated
);

  // stalled result stays put
  `PPT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `PPT_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(x_scale))

  // a stalled output blocks new transactions
  `PPT_ASSERT(a_stall_blocks, out_valid && !out_ready |-> !in_ready)

  // equal planes always count as clipped
  `PPT_ASSERT(a_dinv_sat, out_valid && depth_invalid |-> saturated)

  // nothing shown right after reset
  `PPT_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid)

endmodule

bind perspective_projection_terms ppt_chk u_chk (
  .clk(clk),
  .rst(rst),
  .in_ready(params.ready),
  .out_valid(terms.valid),
  .out_ready(terms.ready),
  .x_scale(terms.x_scale),
  .depth_invalid(terms.depth_invalid),
  .saturated(terms.saturated)
);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for perspective_projection_terms: directed corner
// cases then ~1000 random view set-ups with random stalls on both channels,
// each result checked field by field against a fixed-point projection model
// ----------------------------------------------------------------------------
module tb;

  localparam logic [23:0] FOV_CLAMP = 24'd11730944;
  localparam int          ROM_LEN   = 32;
  localparam longint      LIM40     = 64'sd1099511627776;
  localparam int          STEPS     = ppt_pkg::CORDIC_STEPS;

  typedef struct packed {
    logic               hold;
    logic [23:0]        fov_x_deg;
    logic [30:0]        aspect;
    logic signed [31:0] near_plane;
    logic signed [31:0] far_plane;
  } view_t;

  typedef struct packed {
    logic signed [31:0] x_scale;
    logic signed [31:0] y_scale;
    logic signed [31:0] depth_scale;
    logic signed [31:0] depth_offset;
    logic               depth_invalid;
    logic               saturated;
  } terms_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ppt_in_if  params_if ();
  ppt_out_if terms_if ();

  perspective_projection_terms i_dut (
    .clk    (clk),
    .rst    (rst),
    .params (params_if),
    .terms  (terms_if)
  );

  always #2 clk = ~clk;

  longint               atan_tab [ROM_LEN];
  longint unsigned      deg_factor;
  longint               half_lim;

  view_t  pending_views[$];
  terms_t expected_terms[$];
  int     errors = 0;
  int     send_gap = 0;
  int     recv_gap = 0;
  logic   accepted = 1'b0;

  // arctangent of 1/n in Q60 by series
  function automatic longint unsigned atan_inv(longint unsigned n);
    longint unsigned p, nn, t, k;
    longint acc;
    p = (64'd1 << 60) / n;
    nn = n * n;
    acc = 0;
    k = 0;
    while (p != 0) begin
      t = p / (2 * k + 1);
      if (k[0]) acc -= longint'(t);
      else acc += longint'(t);
      p = p / nn;
      k++;
    end
    return longint'(acc);
  endfunction

  function automatic longint half_angle(longint unsigned fov);
    return longint'((fov * deg_factor + (64'd1 << 26)) >> 27);
  endfunction

  function automatic void build_tables();
    longint unsigned qpi, pi60;
    qpi = 4 * atan_inv(5) - atan_inv(239);
    pi60 = 4 * qpi;
    atan_tab[0] = longint'((qpi + (64'd1 << 29)) >> 30);
    for (int i = 1; i < ROM_LEN; i++)
      atan_tab[i] = longint'((atan_inv(64'd1 << i) + (64'd1 << 29)) >> 30);
    deg_factor = (pi60 + 90 * (64'd1 << 20)) / (180 * (64'd1 << 20));
    half_lim = half_angle(64'(FOV_CLAMP));
  endfunction

  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 64'sd1 << 30;
    y = 0;
    z = ang;
    for (int i = 0; i < STEPS && i < ROM_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS && i < ROM_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint sat_div(longint unsigned mag, logic numneg, longint den,
                                     inout logic clip);
    logic neg;
    longint unsigned ud, q;
    neg = numneg != (den < 0);
    ud = den < 0 ? longint'(0) - den : den;
    if (ud == 0) begin
      clip = 1'b1;
      return (numneg && mag != 0) ? -64'sd2147483648 : 64'sd2147483647;
    end
    q = mag / ud;
    if (neg) begin
      if (q > 64'd2147483648) begin
        clip = 1'b1;
        return -64'sd2147483648;
      end
      return -longint'(q);
    end
    if (q > 64'd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    return longint'(q);
  endfunction

  function automatic longint cot_q16(longint ang, inout logic clip);
    longint c, s;
    longint unsigned mag;
    rotate(ang, c, s);
    mag = (c < 0 ? longint'(0) - c : c) << 16;
    return sat_div(mag, c < 0, s, clip);
  endfunction

  function automatic longint vertical_half(longint hx, longint unsigned asp);
    longint c, s, bx, by, h;
    if (hx < 0) return half_lim;
    rotate(hx, c, s);
    if (c < 0) c = 0;
    if (s < 0) s = 0;
    bx = c * longint'(asp);
    by = s * 65536;
    while (bx >= LIM40 || by >= LIM40) begin
      bx = bx / 2;
      by = by / 2;
    end
    h = vector_angle(bx, by);
    return h < 0 ? 0 : h;
  endfunction

  function automatic terms_t project(view_t v);
    longint unsigned fov, asp, mag;
    longint nr, fr, hx, hy, hw, hy2, xs, ys, d, sm, prod, ds, dof;
    logic clip;
    terms_t r;
    clip = 1'b0;
    fov = 64'(v.fov_x_deg);
    if (fov == 0) fov = 1;
    if (fov > 64'(FOV_CLAMP)) fov = 64'(FOV_CLAMP);
    asp = 64'(v.aspect);
    nr = longint'(v.near_plane);
    fr = longint'(v.far_plane);
    hx = half_angle(fov);
    hy = vertical_half(hx, asp);
    hw = hx + (hx - hy) / 2;
    if (hw > half_lim) hw = half_lim;
    hy2 = vertical_half(hw, asp);
    if (hy2 > half_lim) hy2 = half_lim;
    xs = cot_q16(hw, clip);
    ys = cot_q16(hy2, clip);
    d = fr - nr;
    sm = fr + nr;
    mag = (sm < 0 ? longint'(0) - sm : sm) << 16;
    ds = sat_div(mag, sm > 0, d, clip);
    prod = fr * nr;
    mag = (prod < 0 ? longint'(0) - prod : prod) * 2;
    dof = sat_div(mag, prod > 0, d, clip);
    r.x_scale = xs[31:0];
    r.y_scale = ys[31:0];
    r.depth_scale = ds[31:0];
    r.depth_offset = dof[31:0];
    r.depth_invalid = (d == 0);
    r.saturated = clip;
    return r;
  endfunction

  function automatic view_t mk_view(logic [23:0] f, logic [30:0] a, logic [31:0] n,
                                    logic [31:0] fr);
    view_t v;
    v.hold = 1'b0;
    v.fov_x_deg = f;
    v.aspect = a;
    v.near_plane = n;
    v.far_plane = fr;
    return v;
  endfunction

  function automatic view_t random_view();
    logic [23:0] f;
    logic [30:0] a;
    logic [31:0] n, fr;
    case ($urandom_range(0, 9))
      0: f = 24'($urandom);
      1: f = 24'($urandom_range(0, 16));
      default: f = 24'($urandom_range(1, FOV_CLAMP));
    endcase
    case ($urandom_range(0, 4))
      0: a = 31'($urandom);
      1: a = 31'($urandom >> $urandom_range(1, 31));
      default: a = 31'($urandom_range(32768, 262144));
    endcase
    case ($urandom_range(0, 9))
      0, 1: begin
        n = $urandom;
        fr = $urandom;
      end
      2: begin
        n = $urandom;
        fr = n;
      end
      3: begin
        n = -$signed($urandom_range(1, 1 << 24));
        fr = $urandom >> $urandom_range(0, 16);
      end
      default: begin
        n = $urandom_range(1, 1 << 20);
        fr = n + $urandom_range(1, 1 << 28);
      end
    endcase
    return mk_view(f, a, n, fr);
  endfunction

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  // acceptance and result checking
  always @(posedge clk) begin
    terms_t e;
    view_t v;
    accepted <= !rst && params_if.valid && params_if.ready;
    if (!rst) begin
      if (params_if.valid && params_if.ready) begin
        v = mk_view(params_if.fov_x_deg, params_if.aspect, params_if.near_plane,
                    params_if.far_plane);
        expected_terms.push_back(project(v));
      end
      if (terms_if.valid && terms_if.ready) begin
        if (expected_terms.size() == 0) begin
          $display("%0t unexpected transaction x_scale %0d", $time, terms_if.x_scale);
          errors++;
        end else begin
          e = expected_terms.pop_front();
          check_field("x_scale", e.x_scale, terms_if.x_scale);
          check_field("y_scale", e.y_scale, terms_if.y_scale);
          check_field("depth_scale", e.depth_scale, terms_if.depth_scale);
          check_field("depth_offset", e.depth_offset, terms_if.depth_offset);
          check_field("depth_invalid", e.depth_invalid, terms_if.depth_invalid);
          check_field("saturated", e.saturated, terms_if.saturated);
        end
      end
    end
  end

  // params driver
  always @(negedge clk) begin
    view_t v;
    if (rst) begin
      params_if.valid <= 1'b0;
    end else if (params_if.valid && !accepted) begin
      params_if.valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      params_if.valid <= 1'b0;
    end else if (pending_views.size() > 0 &&
                 !(pending_views[0].hold && expected_terms.size() > 0)) begin
      v = pending_views.pop_front();
      params_if.valid <= 1'b1;
      params_if.fov_x_deg <= v.fov_x_deg;
      params_if.aspect <= v.aspect;
      params_if.near_plane <= v.near_plane;
      params_if.far_plane <= v.far_plane;
      if (pending_views.size() > 100 && $urandom_range(0, 5) == 0)
        send_gap <= $urandom_range(1, 9);
    end else begin
      params_if.valid <= 1'b0;
    end
  end

  // terms receiver
  always @(negedge clk) begin
    if (rst) begin
      terms_if.ready <= 1'b0;
    end else if (pending_views.size() <= 100) begin
      terms_if.ready <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      terms_if.ready <= 1'b0;
    end else begin
      terms_if.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 9);
    end
  end

  initial begin
    view_t v;
    build_tables();

    pending_views.push_back(mk_view(24'd0, 31'd65536, 32'd6554, 32'd6553600));
    pending_views.push_back(mk_view(24'd1, 31'd1, 32'd65536, 32'd131072));
    pending_views.push_back(mk_view(FOV_CLAMP, 31'h7fffffff, 32'd1, 32'h7fffffff));
    pending_views.push_back(mk_view(FOV_CLAMP + 24'd1, 31'd65536, 32'd65536, 32'd65536));
    pending_views.push_back(mk_view(24'hffffff, 31'd0, 32'd0, 32'd0));
    pending_views.push_back(mk_view(24'd5898240, 31'd116508, 32'h80000000, 32'h7fffffff));
    pending_views.push_back(mk_view(24'd3932160, 31'd87381, 32'h7fffffff, 32'h80000000));
    pending_views.push_back(mk_view(24'd5898240, 31'd0, 32'h80000000, 32'h80000000));
    pending_views.push_back(mk_view(24'd11730943, 31'd1, 32'hffff0000, 32'd65536));
    pending_views.push_back(mk_view(24'd65536, 31'h40000000, 32'd655360, 32'd65536));
    pending_views.push_back(mk_view(24'd7864320, 31'd65536, 32'hfff60000, 32'hffff0000));
    pending_views.push_back(mk_view(24'd100, 31'd200, 32'h7fffffff, 32'h7fffffff));
    pending_views.push_back(mk_view(24'd5898240, 31'd65536, 32'd0, 32'd65536));
    pending_views.push_back(mk_view(24'hff0000, 31'h55555555, 32'h55555555, 32'haaaaaaaa));
    pending_views.push_back(mk_view(24'h00ffff, 31'h2aaaaaaa, 32'haaaaaaaa, 32'h55555555));
    for (int i = 0; i < 1000; i++) begin
      v = random_view();
      if (i == 300) v.hold = 1'b1;
      pending_views.push_back(v);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (pending_views.size() == 0 && !params_if.valid);
    wait (expected_terms.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_terms.size() == 0) begin
      $display("PASS perspective_projection_terms");
    end else begin
      $display("FAIL perspective_projection_terms");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL perspective_projection_terms");
    $finish;
  end

endmodule
